// File: rtl/core/hsd_pkg.sv
// Shared types and constants of the head-and-shoulders pattern detector.
`default_nettype none

package hsd_pkg;

    localparam int PRICE_BITS     = 32;
    localparam int WIN_W          = 7;
    localparam int CNT_W          = 8;
    localparam int MAX_WINDOW_DEF = 64;

    localparam logic [WIN_W-1:0] WINDOW_RESET = 7'd20;
    localparam logic [WIN_W-1:0] MIN_WINDOW   = 7'd4;
    localparam logic [CNT_W-1:0] FILL_MAX     = 8'd255;

    typedef struct packed {
        logic [PRICE_BITS-1:0] price;
        logic                  series_end;
    } hsd_in_t;

    typedef struct packed {
        logic center_valid;
        logic center_flag;
        logic series_end_out;
    } hsd_out_t;

    typedef struct packed {
        logic             start;
        logic [WIN_W-1:0] w;
    } hsd_scan_req_t;

    typedef struct packed {
        logic done;
        logic flag;
    } hsd_scan_res_t;

endpackage

`default_nettype wire

// File: rtl/core/head_shoulders_pattern_detector.sv
// Top level of the head-and-shoulders pattern detector.
//
// Price requests enter on in_valid/in_ready, one result request leaves on
// out_valid/out_ready for every price taken. The block holds the last
// 2*MAX_WINDOW prices in a RAM and keeps a fill count of the current series.
// When 2W prices of the series are held, W lies between MIN_WINDOW and
// MAX_WINDOW and the price does not end the series, one comparator pair
// walks the 2W stored prices, one per cycle, and then checks the shoulders
// against the head in the compare states S_CMP1 and S_CMP2. An evaluated
// price passes through the scan and then S_HOLD before the result register
// loads; any other price goes straight to S_HOLD. A new price can be taken
// in the cycle after the result register loads. in_ready is high only while
// no price is in work. The result waits in the output register while the
// receiver stalls, and a finished result is held back until that register
// is free. Reset clears the write pointer, the fill count and all handshake
// state and sets the window size to 20; the RAM contents are not cleared.
// The window size is written through cfg_we/cfg_wdata; the user must write
// it only while the block is idle, as the block itself does not enforce it.
`default_nettype none

module head_shoulders_pattern_detector
    import hsd_pkg::*;
#(
    parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire hsd_in_t          in_data,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output hsd_out_t              out_data,
    input  wire logic             cfg_we,
    input  wire logic [WIN_W-1:0] cfg_wdata
);

    localparam int DEPTH = 2 * MAX_WINDOW;
    localparam int PTR_W = $clog2(DEPTH);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_HOLD
    } state_t;

    state_t            state_reg;
    logic [WIN_W-1:0]  window_reg;
    logic [PTR_W-1:0]  wp_reg;
    logic [CNT_W-1:0]  fill_reg;
    logic              last_reg;
    hsd_out_t          pend_reg;
    logic              out_valid_reg;
    hsd_out_t          out_data_reg;

    logic              in_accept;
    logic [CNT_W-1:0]  fill_inc;
    logic              eval;
    logic              out_load;
    logic              rd_en;
    logic [PTR_W-1:0]  rd_addr;
    logic [PRICE_BITS-1:0] rd_data;
    hsd_scan_req_t     scan_req;
    hsd_scan_res_t     scan_res;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_accept = in_valid && in_ready;
    assign fill_inc  = (fill_reg < FILL_MAX) ? fill_reg + CNT_W'(1) : fill_reg;
    assign eval      = (window_reg >= MIN_WINDOW)
                    && (32'(window_reg) <= 32'(MAX_WINDOW))
                    && (fill_inc >= {window_reg, 1'b0})
                    && !in_data.series_end;
    assign out_load  = (state_reg == S_HOLD) && (!out_valid_reg || out_ready);

    assign scan_req.start = in_accept && eval;
    assign scan_req.w     = window_reg;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    hsd_ram #(
        .WIDTH (PRICE_BITS),
        .DEPTH (DEPTH)
    ) u_history (
        .clk   (clk),
        .we    (in_accept),
        .waddr (wp_reg),
        .wdata (in_data.price),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    hsd_scan #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_scan (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (scan_req),
        .newest  (wp_reg),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .res     (scan_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            window_reg    <= WINDOW_RESET;
            wp_reg        <= '0;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                window_reg <= cfg_wdata;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_accept)
                    begin
                        wp_reg   <= (wp_reg == LAST_PTR) ? '0 : wp_reg + PTR_W'(1);
                        fill_reg <= in_data.series_end ? '0 : fill_inc;
                        last_reg <= in_data.series_end;
                        pend_reg.center_valid   <= 1'b0;
                        pend_reg.center_flag    <= 1'b0;
                        pend_reg.series_end_out <= in_data.series_end;
                        state_reg <= eval ? S_SCAN : S_HOLD;
                    end
                end
                S_SCAN:
                begin
                    if (scan_res.done)
                    begin
                        pend_reg.center_valid   <= 1'b1;
                        pend_reg.center_flag    <= scan_res.flag;
                        pend_reg.series_end_out <= last_reg;
                        state_reg <= S_HOLD;
                    end
                end
                S_HOLD:
                begin
                    if (out_load)
                    begin
                        out_data_reg <= pend_reg;
                        state_reg    <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> !in_ready)
        else $error("price taken while a previous one is still in work");

    a_flag_needs_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(out_data.center_flag && !out_data.center_valid))
        else $error("pattern flag raised without an evaluated window");

    a_end_not_evaluated: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(out_data.series_end_out && out_data.center_valid))
        else $error("last price of a series completed a window");

    a_done_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        scan_res.done |-> (state_reg == S_SCAN))
        else $error("scan finished outside the scan state");

endmodule

`default_nettype wire

// File: rtl/core/hsd_ram.sv
// Generic simple dual-port RAM with registered read data.
`default_nettype none

module hsd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/hsd_scan.sv
// Window scan sequencer with the shared compare unit.
`default_nettype none

module hsd_scan
    import hsd_pkg::*;
#(
    parameter int MAX_WINDOW = MAX_WINDOW_DEF,
    parameter int DEPTH      = 2 * MAX_WINDOW,
    parameter int PTR_W      = $clog2(DEPTH)
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire hsd_scan_req_t         req,
    input  wire logic [PTR_W-1:0]      newest,
    output logic                       rd_en,
    output logic      [PTR_W-1:0]      rd_addr,
    input  wire logic [PRICE_BITS-1:0] rd_data,
    output hsd_scan_res_t              res
);

    localparam int AW = ((PTR_W > CNT_W) ? PTR_W : CNT_W) + 1;
    localparam logic [AW-1:0]    DEPTH_A  = AW'(DEPTH);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_CMP1,
        S_CMP2
    } state_t;

    state_t                  state_reg;
    logic [WIN_W-1:0]        w_reg;
    logic [CNT_W-1:0]        total_reg;
    logic [CNT_W-1:0]        issue_reg;
    logic [PTR_W-1:0]        addr_reg;
    logic                    dv_reg;
    logic [CNT_W-1:0]        dj_reg;
    logic [PRICE_BITS-1:0]   lmax_reg;
    logic [PRICE_BITS-1:0]   hmax_reg;
    logic [PRICE_BITS-1:0]   hmin_reg;
    logic [PRICE_BITS-1:0]   rmax_reg;
    logic                    ok1_reg;
    hsd_scan_res_t           res_reg;

    logic [CNT_W-1:0]        total_req;
    logic [AW-1:0]           nxt_a;
    logic [PTR_W-1:0]        start_addr;
    logic [CNT_W-1:0]        half;
    logic [CNT_W-1:0]        w_ext;
    logic                    in_left;
    logic                    in_head;
    logic [PRICE_BITS-1:0]   a0;
    logic [PRICE_BITS-1:0]   b0;
    logic [PRICE_BITS-1:0]   a1;
    logic [PRICE_BITS-1:0]   b1;
    logic                    gt0;
    logic                    gt1;

    assign total_req = {req.w, 1'b0};
    assign nxt_a     = AW'(newest) + AW'(1);
    assign half      = CNT_W'(w_reg >> 1);
    assign w_ext     = CNT_W'(w_reg);
    assign in_left   = dj_reg < half;
    assign in_head   = !in_left && (dj_reg < w_ext);

    always_comb
    begin
        if (nxt_a >= AW'(total_req))
        begin
            start_addr = PTR_W'(nxt_a - AW'(total_req));
        end
        else
        begin
            start_addr = PTR_W'(nxt_a + DEPTH_A - AW'(total_req));
        end
    end

    // Two magnitude comparators, steered by the sequencer state.
    always_comb
    begin
        a0 = rd_data;
        b0 = rmax_reg;
        a1 = hmin_reg;
        b1 = rd_data;
        case (state_reg)
            S_CMP1:
            begin
                a0 = hmax_reg;
                b0 = lmax_reg;
                a1 = lmax_reg;
                b1 = hmin_reg;
            end
            S_CMP2:
            begin
                a0 = hmax_reg;
                b0 = rmax_reg;
                a1 = rmax_reg;
                b1 = hmin_reg;
            end
            default:
            begin
                if (in_left)
                begin
                    b0 = lmax_reg;
                end
                else if (in_head)
                begin
                    b0 = hmax_reg;
                end
            end
        endcase
    end

    assign gt0 = a0 > b0;
    assign gt1 = a1 > b1;

    assign rd_en   = (state_reg == S_SCAN) && (issue_reg < total_reg);
    assign rd_addr = addr_reg;
    assign res     = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            dv_reg    <= 1'b0;
            res_reg   <= '0;
        end
        else
        begin
            res_reg.done <= 1'b0;
            dv_reg       <= rd_en;
            dj_reg       <= issue_reg;
            case (state_reg)
                S_IDLE:
                begin
                    if (req.start)
                    begin
                        w_reg     <= req.w;
                        total_reg <= total_req;
                        issue_reg <= '0;
                        addr_reg  <= start_addr;
                        state_reg <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    if (rd_en)
                    begin
                        issue_reg <= issue_reg + CNT_W'(1);
                        addr_reg  <= (addr_reg == LAST_PTR) ? '0 : addr_reg + PTR_W'(1);
                    end
                    if (dv_reg)
                    begin
                        if (in_left)
                        begin
                            if (dj_reg == '0 || gt0)
                            begin
                                lmax_reg <= rd_data;
                            end
                        end
                        else if (in_head)
                        begin
                            if (dj_reg == half || gt0)
                            begin
                                hmax_reg <= rd_data;
                            end
                            if (dj_reg == half || gt1)
                            begin
                                hmin_reg <= rd_data;
                            end
                        end
                        else
                        begin
                            if (dj_reg == w_ext || gt0)
                            begin
                                rmax_reg <= rd_data;
                            end
                        end
                        if (dj_reg == total_reg - CNT_W'(1))
                        begin
                            state_reg <= S_CMP1;
                        end
                    end
                end
                S_CMP1:
                begin
                    ok1_reg   <= gt0 && gt1;
                    state_reg <= S_CMP2;
                end
                S_CMP2:
                begin
                    res_reg.done <= 1'b1;
                    res_reg.flag <= ok1_reg && gt0 && gt1;
                    state_reg    <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// File: bench/head_shoulders_pattern_detector_test.sv
// Self-checking testbench for the head-and-shoulders pattern detector.
`timescale 1ns / 1ps

module head_shoulders_pattern_detector_test;
    import hsd_pkg::*;

    localparam int HIST_DEPTH    = 2 * MAX_WINDOW_DEF;
    localparam int SETTLE_CYCLES = 2 * MAX_WINDOW_DEF + 16;
    localparam int IDLE_LIMIT    = 4000;
    localparam int REPORT_LIMIT  = 10;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             in_valid  = 1'b0;
    logic             in_ready;
    hsd_in_t          in_data   = '0;
    logic             out_valid;
    logic             out_ready = 1'b0;
    hsd_out_t         out_data;
    logic             cfg_we    = 1'b0;
    logic [WIN_W-1:0] cfg_wdata = '0;

    logic [PRICE_BITS-1:0] price_hist [HIST_DEPTH];
    logic [WIN_W-1:0]      hist_wr     = '0;
    logic [CNT_W-1:0]      series_fill = '0;
    logic [WIN_W-1:0]      window_len  = WINDOW_RESET;
    hsd_out_t              predicted_centers [$];

    int sent_prices     = 0;
    int checked_results = 0;
    int flags_seen      = 0;
    int mismatches      = 0;
    int window_writes   = 0;
    int sender_calm     = 0;
    int receiver_calm   = 0;

    head_shoulders_pattern_detector i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic hsd_out_t detect_pattern(hsd_in_t req);
        hsd_out_t              res;
        logic [WIN_W-1:0]      newest;
        logic [WIN_W-1:0]      idx;
        logic [PRICE_BITS-1:0] v;
        logic [PRICE_BITS-1:0] lsh_peak;
        logic [PRICE_BITS-1:0] top_hi;
        logic [PRICE_BITS-1:0] top_lo;
        logic [PRICE_BITS-1:0] rsh_peak;
        int                    w;
        int                    half;
        int                    j;
        newest = hist_wr;
        price_hist[newest] = req.price;
        hist_wr = newest + 1'b1;
        if (series_fill != FILL_MAX)
            series_fill = series_fill + 1'b1;
        w = window_len;
        half = w / 2;
        res = '0;
        res.series_end_out = req.series_end;
        lsh_peak = '0;
        top_hi = '0;
        top_lo = '0;
        rsh_peak = '0;
        if (w >= MIN_WINDOW && w <= MAX_WINDOW_DEF && series_fill >= 2 * w && !req.series_end)
        begin
            res.center_valid = 1'b1;
            for (j = 0; j < 2 * w; j++)
            begin
                idx = newest - WIN_W'(2 * w - 1 - j);
                v = price_hist[idx];
                if (j < half)
                begin
                    if (j == 0 || v > lsh_peak)
                        lsh_peak = v;
                end
                else if (j < w)
                begin
                    if (j == half || v > top_hi)
                        top_hi = v;
                    if (j == half || v < top_lo)
                        top_lo = v;
                end
                else if (j == w || v > rsh_peak)
                begin
                    rsh_peak = v;
                end
            end
            res.center_flag = (lsh_peak < top_hi) && (rsh_peak < top_hi) &&
                              (lsh_peak > top_lo) && (rsh_peak > top_lo);
        end
        if (req.series_end)
            series_fill = '0;
        return res;
    endfunction

    function automatic int draw_wait(inout int calm);
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0)
        begin
            calm = $urandom_range(8, 40);
            return 0;
        end
        return $urandom_range(0, 5);
    endfunction

    task automatic send_price(input logic [PRICE_BITS-1:0] price, input logic last);
        hsd_in_t req;
        int      gap;
        logic    taken;
        req.price = price;
        req.series_end = last;
        gap = draw_wait(sender_calm);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= req;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = in_ready;
            @(posedge clk);
        end
        predicted_centers.push_back(detect_pattern(req));
        sent_prices++;
    endtask

    task automatic wait_idle(input int settle);
        in_valid <= 1'b0;
        while (predicted_centers.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic write_window(input logic [WIN_W-1:0] value);
        wait_idle(4);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        window_len = value;
        window_writes++;
    endtask

    // The shape repeats every 2w samples, so every window aligned to that period is shaped.
    task automatic send_shaped_series(input int w, input int extra, input bit broken,
                                      input bit closes);
        logic [PRICE_BITS-1:0] base;
        logic [PRICE_BITS-1:0] span;
        logic [PRICE_BITS-1:0] value;
        int                    half;
        int                    len;
        int                    k;
        int                    pos;
        int                    peak_pos;
        int                    dip_pos;
        int                    flaw_pos;
        half = w / 2;
        len = 2 * w + extra;
        if ($urandom_range(0, 1) == 0)
            span = $urandom_range(2, 8);
        else
            span = $urandom_range(2, 32'hFFFF_FFFF);
        base = $urandom_range(0, 32'hFFFF_FFFF - span);
        peak_pos = $urandom_range(half, w - 1);
        dip_pos = half + (peak_pos - half + $urandom_range(1, w - half - 1)) % (w - half);
        flaw_pos = -1;
        if (broken)
        begin
            flaw_pos = $urandom_range(0, half + w - 1);
            if (flaw_pos >= half)
                flaw_pos = flaw_pos + w - half;
        end
        for (k = 0; k < len; k++)
        begin
            pos = k % (2 * w);
            if (pos == peak_pos)
                value = base + span;
            else if (pos == dip_pos)
                value = base;
            else if (pos == flaw_pos)
                value = ($urandom_range(0, 1) == 1) ? base + span : base;
            else if (pos >= half && pos < w)
                value = base + $urandom_range(0, span);
            else
                value = base + $urandom_range(1, span - 1);
            send_price(value, closes && k == len - 1);
        end
    endtask

    task automatic send_noise_series(input int len, input bit narrow);
        logic [PRICE_BITS-1:0] value;
        int                    k;
        for (k = 0; k < len; k++)
        begin
            if (narrow)
                value = $urandom_range(0, 3);
            else
                value = $urandom();
            send_price(value, k == len - 1 || $urandom_range(0, 31) == 0);
        end
    endtask

    task automatic test_directed_cases();
        // With the default window, a one-sample series and a short series are never evaluated.
        send_price(32'hFFFF_FFFF, 1'b1);
        send_price(32'h0000_0000, 1'b0);
        send_price(32'h0001_8000, 1'b1);
        write_window(7'd4);
        // The head spans the whole price range, so the first full window matches.
        send_price(32'd5, 1'b0);
        send_price(32'd6, 1'b0);
        send_price(32'h0000_0000, 1'b0);
        send_price(32'hFFFF_FFFF, 1'b0);
        send_price(32'd7, 1'b0);
        send_price(32'd8, 1'b0);
        send_price(32'd9, 1'b0);
        send_price(32'd10, 1'b0);
        send_price(32'd3, 1'b0);
        send_price(32'd4, 1'b1);
        // A right shoulder equal to the head maximum breaks the strict ordering.
        send_price(32'd10, 1'b0);
        send_price(32'd20, 1'b0);
        send_price(32'd5, 1'b0);
        send_price(32'd30, 1'b0);
        send_price(32'd11, 1'b0);
        send_price(32'd12, 1'b0);
        send_price(32'd13, 1'b0);
        send_price(32'd30, 1'b0);
        send_price(32'd14, 1'b1);
    endtask

    task automatic test_disabled_windows();
        int n;
        write_window(7'd65);
        send_shaped_series(65, 6, 1'b0, 1'b1);
        for (n = 0; n < 5; n++)
        begin
            write_window((n < 4) ? WIN_W'(n) : 7'd127);
            send_noise_series(8, n[0]);
        end
    endtask

    task automatic test_random_windows();
        int round;
        int w;
        int pick;
        for (round = 0; round < 7; round++)
        begin
            if (round % 4 == 3)
                w = $urandom_range(17, 24);
            else
                w = $urandom_range(4, 10);
            write_window(w[WIN_W-1:0]);
            repeat ($urandom_range(1, 3))
            begin
                pick = $urandom_range(0, 9);
                if (pick < 8)
                    send_shaped_series(w, $urandom_range(1, w), pick >= 6, 1'b1);
                else
                    send_noise_series($urandom_range(1, 2 * w + 8), pick == 9);
            end
        end
    endtask

    task automatic test_window_change_mid_series();
        write_window(7'd8);
        send_shaped_series(8, 4, 1'b0, 1'b0);
        write_window(7'd5);
        send_shaped_series(5, 6, 1'b0, 1'b0);
        write_window(7'd12);
        send_shaped_series(12, 2, 1'b1, 1'b1);
        write_window(7'd4);
        send_shaped_series(4, 3, 1'b0, 1'b0);
        write_window(7'd10);
        send_shaped_series(10, 1, 1'b0, 1'b1);
    endtask

    task automatic test_widest_window();
        // The series runs past the point where the fill count saturates.
        write_window(7'd64);
        send_shaped_series(64, 134, 1'b0, 1'b1);
    endtask

    initial
    begin : result_checker
        int       stall;
        logic     seen;
        hsd_out_t got;
        hsd_out_t want;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = draw_wait(receiver_calm);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            seen = 1'b0;
            while (!seen)
            begin
                @(negedge clk);
                seen = out_valid;
                got = out_data;
                @(posedge clk);
            end
            if (predicted_centers.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected result: valid=%b flag=%b end=%b",
                             got.center_valid, got.center_flag, got.series_end_out);
            end
            else
            begin
                want = predicted_centers.pop_front();
                checked_results++;
                if (want.center_flag)
                    flags_seen++;
                if (got.center_valid !== want.center_valid ||
                    got.center_flag !== want.center_flag ||
                    got.series_end_out !== want.series_end_out)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("result %0d: expected valid=%b flag=%b end=%b, got %b %b %b",
                                 checked_results, want.center_valid, want.center_flag,
                                 want.series_end_out, got.center_valid, got.center_flag,
                                 got.series_end_out);
                end
            end
        end
    end

    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(negedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("no request moved for %0d cycles", IDLE_LIMIT);
        $display("head_shoulders_pattern_detector regression: fail");
        $finish;
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_cases();
        test_disabled_windows();
        test_random_windows();
        test_window_change_mid_series();
        test_widest_window();
        wait_idle(SETTLE_CYCLES);
        $display("Checked %0d results for %0d prices across %0d window writes, %0d pattern hits.",
                 checked_results, sent_prices, window_writes, flags_seen);
        $display("Covered disabled and oversized windows, window changes inside a series "
                 , "and fill-count saturation at the widest window.");
        if (mismatches == 0 && predicted_centers.size() == 0)
            $display("head_shoulders_pattern_detector regression: pass");
        else
            $display("head_shoulders_pattern_detector regression: fail");
        $finish;
    end

endmodule

// File: files.f
rtl/core/hsd_pkg.sv
rtl/core/hsd_ram.sv
rtl/core/hsd_scan.sv
rtl/core/head_shoulders_pattern_detector.sv
bench/head_shoulders_pattern_detector_test.sv
